@@ src/hipsm_pkg.sv @@
package hipsm_pkg;

   localparam logic [1:0] CMD_PDU  = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_POLL = 2'd2;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_HDR    = 3'd1;
   localparam logic [2:0] ACT_TP     = 3'd2;
   localparam logic [2:0] ACT_DIRECT = 3'd3;
   localparam logic [2:0] ACT_AUDIT  = 3'd4;

   localparam logic [7:0] MID_INIT      = 8'd0;
   localparam logic [7:0] MID_CLOSE     = 8'd1;
   localparam logic [7:0] MID_KEEPALIVE = 8'd2;
   localparam logic [7:0] MID_TP        = 8'd3;
   localparam logic [7:0] MID_DIRECT    = 8'd4;
   localparam logic [7:0] MID_AUDIT     = 8'd5;

   localparam logic [7:0] MTYPE_REQUEST = 8'd0;
   localparam logic [7:0] MTYPE_PUBLISH = 8'd2;

   localparam logic [7:0] VER_NONE = 8'd0;
   localparam logic [7:0] VER_MAX  = 8'd2;

   localparam logic [7:0] STAT_OK         = 8'd0;
   localparam logic [7:0] STAT_TOO_FEW    = 8'd5;
   localparam logic [7:0] STAT_ADJUSTED   = 8'd8;
   localparam logic [7:0] STAT_VER_UNSUP  = 8'd14;
   localparam logic [7:0] STAT_RESTRICTED = 8'd16;

   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_NORMAL  = 2'd1;
   localparam logic [1:0] CAUSE_ABORT   = 2'd2;
   localparam logic [1:0] CAUSE_TIMEOUT = 2'd3;

   localparam logic [3:0]  LEN_HDR      = 4'd8;
   localparam logic [3:0]  LEN_INIT     = 4'd13;
   localparam logic [15:0] INIT_MIN_LEN = 16'd13;

   localparam logic [19:0] TO_MAX_MS    = 20'd600000;
   localparam logic [19:0] TO_MIN_MS    = 20'd1000;
   localparam logic [9:0]  TO_DEFAULT_S = 10'd90;
   localparam logic [15:0] IDLE_MAX     = 16'hFFFF;

   // Milliseconds to seconds: floor(x * DIV_K / 2**DIV_SHIFT) equals x / 1000 for x below 2**20.
   localparam int          DIV_SHIFT = 30;
   localparam logic [40:0] DIV_K     = 41'd1073742;

   typedef struct packed {
      logic        active;
      logic [1:0]  version;
      logic [9:0]  timeout_s;
      logic [15:0] idle;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      active:    1'b0,
      version:   2'd1,
      timeout_s: TO_DEFAULT_S,
      idle:      16'd0
   };

   typedef struct packed {
      logic      we;
      entry_type entry;
   } upd_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  session;
      logic [15:0] received_len;
      logic [7:0]  hdr_version;
      logic [7:0]  hdr_msg_type;
      logic [7:0]  hdr_msg_id;
      logic [15:0] hdr_seq;
      logic [15:0] hdr_length;
      logic [31:0] requested_timeout_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic        may_send;
      logic [1:0]  resp_version;
      logic [2:0]  resp_msg_id;
      logic [7:0]  resp_status;
      logic [15:0] resp_seq;
      logic [3:0]  resp_length;
      logic [19:0] granted_timeout_ms;
      logic [1:0]  close_cause;
   } rsp_type;

endpackage

@@ src/hipsm_in_stage.sv @@
module hipsm_in_stage import hipsm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   input  logic    advance,
   output logic    held_valid,
   output req_type held_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign in_ready   = !valid_ff || advance;
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

@@ src/hipsm_table.sv @@
module hipsm_table import hipsm_pkg::*; #(
   parameter int NUM_SESSIONS = 8,
   parameter int IDX_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             tick,
   input  upd_type          upd,
   input  logic [IDX_W-1:0] idx,
   output entry_type        rd_entry
);

   entry_type table_ff [NUM_SESSIONS];
   entry_type table_in [NUM_SESSIONS];

   assign rd_entry = table_ff[idx];

   always_comb begin
      for (int i = 0; i < NUM_SESSIONS; i++) begin
         table_in[i] = table_ff[i];
         if (tick && table_ff[i].active && table_ff[i].idle != IDLE_MAX) begin
            table_in[i].idle = table_ff[i].idle + 16'd1;
         end
         if (upd.we && idx == IDX_W'(i)) begin
            table_in[i] = upd.entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SESSIONS; i++) begin
         if (reset) begin
            table_ff[i] <= ENTRY_RESET;
         end else begin
            table_ff[i] <= table_in[i];
         end
      end
   end

endmodule

@@ src/hipsm_eval.sv @@
module hipsm_eval import hipsm_pkg::*; #(
   parameter int NUM_SESSIONS = 8
) (
   input  logic      fire,
   input  req_type   req,
   input  entry_type cur,
   output logic      tick,
   output upd_type   upd,
   output rsp_type   rsp
);

   logic        in_range;
   logic [1:0]  rver;
   logic [7:0]  status;
   logic [19:0] to_ms;
   logic        to_adj;
   logic [40:0] prod;
   logic [9:0]  to_s;
   entry_type   nxt;

   assign in_range = {29'd0, req.session} < 32'(NUM_SESSIONS);
   assign tick     = fire && req.command == CMD_TICK;

   always_comb begin
      to_adj = 1'b1;
      if (req.requested_timeout_ms > 32'(TO_MAX_MS)) begin
         to_ms = TO_MAX_MS;
      end else if (req.requested_timeout_ms < 32'(TO_MIN_MS)) begin
         to_ms = TO_MIN_MS;
      end else begin
         to_ms  = req.requested_timeout_ms[19:0];
         to_adj = 1'b0;
      end
      prod = 41'(to_ms) * DIV_K;
      to_s = prod[DIV_SHIFT +: 10];
   end

   always_comb begin
      rsp    = '0;
      upd.we = 1'b0;
      nxt    = cur;
      rver   = (req.hdr_version > VER_MAX) ? VER_MAX[1:0] : req.hdr_version[1:0];
      status = (req.hdr_version > VER_MAX) ? STAT_VER_UNSUP : STAT_OK;
      case (req.command)
         CMD_PDU: begin
            if (in_range && req.received_len != 16'd0) begin
               if (req.received_len != req.hdr_length) begin
                  upd.we          = 1'b1;
                  nxt             = ENTRY_RESET;
                  rsp.close_cause = cur.active ? CAUSE_ABORT : CAUSE_NONE;
               end else if (req.hdr_version == VER_NONE) begin
                  upd.we = 1'b0;
               end else if (cur.active && rver != cur.version) begin
                  upd.we = 1'b0;
               end else if (req.hdr_msg_type != MTYPE_REQUEST
                            && req.hdr_msg_type != MTYPE_PUBLISH
                            && req.hdr_msg_id == MID_INIT) begin
                  upd.we          = 1'b1;
                  nxt             = ENTRY_RESET;
                  rsp.close_cause = cur.active ? CAUSE_ABORT : CAUSE_NONE;
               end else if (req.hdr_msg_type == MTYPE_PUBLISH) begin
                  upd.we = 1'b0;
               end else if (req.hdr_msg_id > MID_AUDIT) begin
                  upd.we          = 1'b1;
                  nxt             = ENTRY_RESET;
                  rsp.close_cause = cur.active ? CAUSE_ABORT : CAUSE_NONE;
               end else begin
                  rsp.action      = ACT_HDR;
                  rsp.resp_length = LEN_HDR;
                  case (req.hdr_msg_id)
                     MID_INIT: begin
                        if (req.received_len < INIT_MIN_LEN) begin
                           status = STAT_TOO_FEW;
                        end else if (cur.active) begin
                           status = STAT_RESTRICTED;
                        end else begin
                           if (to_adj) begin
                              status = STAT_ADJUSTED;
                           end
                           upd.we                 = 1'b1;
                           nxt.active             = 1'b1;
                           nxt.version            = rver;
                           nxt.timeout_s          = to_s;
                           nxt.idle               = 16'd0;
                           rsp.granted_timeout_ms = to_ms;
                           rsp.resp_length        = LEN_INIT;
                        end
                     end
                     MID_CLOSE: begin
                        upd.we          = 1'b1;
                        nxt             = ENTRY_RESET;
                        rsp.close_cause = cur.active ? CAUSE_NORMAL : CAUSE_NONE;
                     end
                     MID_KEEPALIVE: begin
                        upd.we = 1'b0;
                     end
                     MID_TP, MID_DIRECT: begin
                        if (!cur.active) begin
                           status = STAT_RESTRICTED;
                        end else begin
                           rsp.action      = (req.hdr_msg_id == MID_TP) ? ACT_TP : ACT_DIRECT;
                           rsp.resp_length = 4'd0;
                        end
                     end
                     default: begin
                        rsp.action      = ACT_AUDIT;
                        rsp.resp_length = 4'd0;
                     end
                  endcase
                  rsp.resp_version = rver;
                  rsp.resp_msg_id  = req.hdr_msg_id[2:0];
                  rsp.resp_status  = status;
                  rsp.resp_seq     = req.hdr_seq;
                  rsp.may_send     = nxt.active || req.hdr_msg_id == MID_CLOSE;
                  if (nxt.active) begin
                     upd.we   = 1'b1;
                     nxt.idle = 16'd0;
                  end
               end
            end
         end
         CMD_POLL: begin
            if (in_range && cur.active && cur.idle > {6'd0, cur.timeout_s}) begin
               upd.we          = 1'b1;
               nxt             = ENTRY_RESET;
               rsp.close_cause = CAUSE_TIMEOUT;
            end
         end
         default: begin
            upd.we = 1'b0;
         end
      endcase
      upd.entry = nxt;
      upd.we    = upd.we && fire;
   end

endmodule

@@ src/hipsm_out_stage.sv @@
module hipsm_out_stage import hipsm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    can_load,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ src/hart_ip_session_manager.sv @@
// Accepted transactions are held in the input register; results go to the output register.
// Throughput: one transaction per cycle unless stalled; table read and update share a cycle.
// Back-pressure on the result side stalls the input register once both stages are full.
// Reset is synchronous and active high; it empties both stages and returns every
// session entry to inactive, version 1, 90 s timeout, idle count zero.
module hart_ip_session_manager import hipsm_pkg::*; #(
   parameter int NUM_SESSIONS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // session, received_len, hdr_version, hdr_msg_type, hdr_msg_id, hdr_seq, hdr_length,
   // requested_timeout_ms, zero fill.
   input  logic [111:0] req_tdata,
   // command.
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // may_send, resp_version, resp_msg_id, resp_status, resp_seq, resp_length,
   // granted_timeout_ms, close_cause.
   output logic [55:0]  rsp_tdata,
   // action.
   output logic [2:0]   rsp_tuser
);

   localparam int IDX_W = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;

   req_type    req_in;
   req_type    req_held;
   logic       held_valid;
   logic       advance;
   logic       fire;
   logic       tick;
   upd_type    upd;
   entry_type  cur;
   rsp_type    rsp_new;
   rsp_type    rsp_out;

   assign req_in.command              = req_tuser;
   assign req_in.session              = req_tdata[2:0];
   assign req_in.received_len         = req_tdata[18:3];
   assign req_in.hdr_version          = req_tdata[26:19];
   assign req_in.hdr_msg_type         = req_tdata[34:27];
   assign req_in.hdr_msg_id           = req_tdata[42:35];
   assign req_in.hdr_seq              = req_tdata[58:43];
   assign req_in.hdr_length           = req_tdata[74:59];
   assign req_in.requested_timeout_ms = req_tdata[106:75];

   assign fire = held_valid && advance;

   hipsm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_in),
      .advance    (advance),
      .held_valid (held_valid),
      .held_data  (req_held)
   );

   hipsm_table #(
      .NUM_SESSIONS (NUM_SESSIONS),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick),
      .upd      (upd),
      .idx      (IDX_W'(req_held.session)),
      .rd_entry (cur)
   );

   hipsm_eval #(
      .NUM_SESSIONS (NUM_SESSIONS)
   ) u_eval (
      .fire (fire),
      .req  (req_held),
      .cur  (cur),
      .tick (tick),
      .upd  (upd),
      .rsp  (rsp_new)
   );

   hipsm_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (rsp_new),
      .can_load  (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign rsp_tuser = rsp_out.action;
   assign rsp_tdata = {rsp_out.close_cause, rsp_out.granted_timeout_ms, rsp_out.resp_length,
                       rsp_out.resp_seq, rsp_out.resp_status, rsp_out.resp_msg_id,
                       rsp_out.resp_version, rsp_out.may_send};

endmodule

@@ src/hipsm_checker.sv @@
module hipsm_checker import hipsm_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [55:0]  rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result transaction changed or was dropped.");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("Accepted transaction produced no result in time.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ACT_NONE |-> rsp_tdata[53:0] == 54'd0)
      else $error("Result without action carries header fields.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[53:34] != 20'd0
      |-> rsp_tuser == ACT_HDR && rsp_tdata[33:30] == LEN_INIT && rsp_tdata[0])
      else $error("Granted timeout without a full initiate response.");

   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("Result valid right after reset.");

endmodule

bind hart_ip_session_manager hipsm_checker u_checker (.*);
